### sv/ett_pkg.sv
// ----------------------------------------------------------------------------
// ett_pkg
// Shared types, opcodes, status codes and date helpers for the earliest
// timestamp table.
// ----------------------------------------------------------------------------
package ett_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ENTRY_W         = 50;

    localparam logic [2:0] OP_INSERT    = 3'd0;
    localparam logic [2:0] OP_COUNT     = 3'd1;
    localparam logic [2:0] OP_READ_MIN  = 3'd2;
    localparam logic [2:0] OP_DEL_MIN   = 3'd3;
    localparam logic [2:0] OP_DEL_OWNER = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [3:0] MONTH_MAX  = 4'd12;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] owner_id;
        logic [4:0]  day_in;
        logic [3:0]  month_in;
        logic [13:0] year_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  tally;
        logic [15:0] first_owner;
        logic [4:0]  first_day;
        logic [3:0]  first_month;
        logic [13:0] first_year;
        logic [4:0]  first_hour;
        logic [5:0]  first_minute;
    } out_word_t;

    // Stored entry; year..minute packed in ordering significance.
    typedef struct packed {
        logic [15:0] owner;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } entry_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd2:                     r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
            default:                  r = 5'd31;
        endcase
        return r;
    endfunction

    // Leap: /4 is a mask; /100 and /400 via the 14-bit year split by a
    // small compare chain on the quotient by 100 computed with a reciprocal.
    function automatic logic leap_year(input logic [13:0] y);
        logic [27:0] prod;
        logic [7:0]  q;
        logic [13:0] rem;
        logic        div100;
        logic        div400;
        prod   = 28'(y) * 28'd10486;          // ~2^20/100
        q      = prod[27:20];
        rem    = y - 14'(q) * 14'd100;
        if (rem >= 14'd100)
        begin
            q   = q + 8'd1;
            rem = rem - 14'd100;
        end
        div100 = (rem == 14'd0);
        div400 = div100 && (q[1:0] == 2'b00);
        return (y[1:0] == 2'b00) && (!div100 || div400);
    endfunction

    function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
                                     input logic [13:0] y);
        logic [5:0] lim;
        lim = {1'b0, month_len(m)};
        if (m == 4'd2 && leap_year(y))
            lim = lim + 6'd1;
        return (y != 14'd0) && (m != 4'd0) && (m <= MONTH_MAX) && (d != 5'd0)
            && ({1'b0, d} <= lim);
    endfunction

endpackage

### sv/ett_ram.sv
// ----------------------------------------------------------------------------
// ett_ram
// Generic single-port-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ett_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### sv/earliest_timestamp_table_core.sv
// ----------------------------------------------------------------------------
// earliest_timestamp_table_core
// Table of owner/date/time entries with insert, count on date, read and
// delete of the earliest entry, and delete of all entries of an owner.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel carries one request word (in_valid, in_stall, in_data).
//   out_* channel carries one response word per request.
//   One request is handled at a time; in_stall is high while busy or while
//   a response waits in the output register.
//   Insert and unused opcodes need no RAM read; count and read earliest
//   read every held entry, and delete earliest then also moves the last
//   entry into the freed slot. Delete by owner handles each entry in turn
//   (read, compare, and for each entry it removes, move the last entry in).
//   Entries are read one at a time through the single read port of the
//   entry RAM.
//   Reset clears the entry count; RAM contents need no clearing because
//   only positions below the count are read.
//   While out_stall is high a pending response word holds and no new request
//   is taken.
// ----------------------------------------------------------------------------
module earliest_timestamp_table_core #(
    parameter int TABLE_DEPTH = ett_pkg::TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ett_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ett_pkg::out_word_t out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FETCH = 5'b00100,
        S_MOVE  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    ett_pkg::in_word_t  req_reg, req_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;      // address being read
    logic               rd_pend_reg, rd_pend_next;
    logic [AW-1:0]      best_reg, best_next;
    ett_pkg::entry_t    best_ent_reg, best_ent_next;
    logic               have_best_reg, have_best_next;
    logic [6:0]         tally_reg, tally_next;
    logic               out_valid_reg, out_valid_next;
    ett_pkg::out_word_t out_reg, out_next;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [ett_pkg::ENTRY_W-1:0] wdata, rdata;
    ett_pkg::entry_t      rd_ent, req_ent;

    ett_ram #(.WIDTH(ett_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_ent  = ett_pkg::entry_t'(rdata);
    assign req_ent = '{owner: req_reg.owner_id, year: req_reg.year_in,
                       month: req_reg.month_in, day: req_reg.day_in,
                       hour: req_reg.hour_in, minute: req_reg.minute_in};

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sequence one request through the RAM
    always_comb
    begin
        logic [CW-1:0] last;
        logic [AW-1:0] rd_pos;
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rd_pend_next   = 1'b0;
        best_next      = best_reg;
        best_ent_next  = best_ent_reg;
        have_best_next = have_best_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        raddr          = idx_reg[AW-1:0];
        last           = count_reg - CW'(1);
        rd_pos         = AW'(idx_reg - CW'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    req_next       = in_data;
                    idx_next       = '0;
                    have_best_next = 1'b0;
                    tally_next     = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                out_next = '0;
                unique case (req_reg.opcode) inside
                    ett_pkg::OP_INSERT:
                    begin
                        if (!ett_pkg::date_ok(req_reg.day_in, req_reg.month_in,
                                req_reg.year_in) || req_reg.hour_in > ett_pkg::HOUR_MAX
                                || req_reg.minute_in > ett_pkg::MINUTE_MAX)
                            out_next.status = ett_pkg::ST_BAD;
                        else if (count_reg >= CW'(TABLE_DEPTH))
                            out_next.status = ett_pkg::ST_FULL;
                        else
                        begin
                            we         = 1'b1;
                            waddr      = count_reg[AW-1:0];
                            wdata      = req_ent;
                            count_next = count_reg + CW'(1);
                        end
                        out_next.tally = 7'(count_next);
                        state_next     = S_DONE;
                    end
                    ett_pkg::OP_COUNT, ett_pkg::OP_READ_MIN, ett_pkg::OP_DEL_MIN:
                    begin
                        if (req_reg.opcode == ett_pkg::OP_COUNT &&
                            !ett_pkg::date_ok(req_reg.day_in, req_reg.month_in,
                                              req_reg.year_in))
                        begin
                            out_next.status = ett_pkg::ST_BAD;
                            state_next      = S_DONE;
                        end
                        else if (req_reg.opcode != ett_pkg::OP_COUNT &&
                                 count_reg == '0)
                        begin
                            out_next.status = ett_pkg::ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // Compare the word returned last cycle
                            if (rd_pend_reg)
                            begin
                                if (req_reg.opcode == ett_pkg::OP_COUNT)
                                begin
                                    if (rd_ent.day == req_reg.day_in &&
                                        rd_ent.month == req_reg.month_in &&
                                        rd_ent.year == req_reg.year_in)
                                        tally_next = tally_reg + 7'd1;
                                end
                                else if (!have_best_reg ||
                                         rd_ent[33:0] < best_ent_reg[33:0])
                                begin
                                    best_next      = rd_pos;
                                    best_ent_next  = rd_ent;
                                    have_best_next = 1'b1;
                                end
                            end
                            if (idx_reg < count_reg)
                            begin
                                rd_pend_next = 1'b1;
                                idx_next     = idx_reg + CW'(1);
                            end
                            else if (req_reg.opcode == ett_pkg::OP_COUNT)
                            begin
                                out_next.tally = tally_next;
                                state_next     = S_DONE;
                            end
                            else
                            begin
                                out_next.first_owner  = best_ent_next.owner;
                                out_next.first_day    = best_ent_next.day;
                                out_next.first_month  = best_ent_next.month;
                                out_next.first_year   = best_ent_next.year;
                                out_next.first_hour   = best_ent_next.hour;
                                out_next.first_minute = best_ent_next.minute;
                                if (req_reg.opcode == ett_pkg::OP_READ_MIN)
                                begin
                                    out_next.tally = 7'(count_reg);
                                    state_next     = S_DONE;
                                end
                                else
                                begin
                                    // Fetch the last entry to fill the hole
                                    out_next.tally = 7'd1;
                                    raddr          = last[AW-1:0];
                                    idx_next       = last;
                                    state_next     = S_MOVE;
                                end
                            end
                        end
                    end
                    ett_pkg::OP_DEL_OWNER:
                    begin
                        if (idx_reg < count_reg)
                        begin
                            idx_next   = idx_reg;
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            out_next.tally = tally_reg;
                            state_next     = S_DONE;
                        end
                    end
                    default:
                    begin
                        out_next.tally = 7'(count_reg);
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_FETCH:
            begin
                // Data for idx arrives now; on match pull in the last entry
                out_next = '0;
                if (rd_ent.owner == req_reg.owner_id)
                begin
                    tally_next = tally_reg + 7'd1;
                    raddr      = last[AW-1:0];
                    best_next  = idx_reg[AW-1:0];
                    state_next = S_MOVE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    raddr      = AW'(idx_next);
                    state_next = S_SCAN;
                end
            end
            S_MOVE:
            begin
                // Write the last entry into the freed slot and shrink
                we         = 1'b1;
                waddr      = best_reg;
                wdata      = rdata;
                count_next = last;
                if (req_reg.opcode == ett_pkg::OP_DEL_MIN)
                    state_next = S_DONE;
                else
                begin
                    idx_next   = CW'(best_reg);
                    state_next = S_SCAN;
                end
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        best_reg      <= best_next;
        best_ent_reg  <= best_ent_next;
        have_best_reg <= have_best_next;
        tally_reg     <= tally_next;
        out_reg       <= out_next;
    end

endmodule

### sv/ett_checker.sv
// ----------------------------------------------------------------------------
// ett_checker
// Port-level checks on the earliest timestamp table.
// ----------------------------------------------------------------------------
module ett_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input ett_pkg::out_word_t out_data
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed under stall");

    // No request is taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken with a result pending");

    // An accepted request is followed by a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("ready straight after accept");

    // Error results carry no entry
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ett_pkg::ST_OK |->
        out_data.first_owner == 16'd0 && out_data.first_year == 14'd0)
        else $error("entry fields set on error");

endmodule

bind earliest_timestamp_table_core ett_checker u_ett_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

### tb/earliest_timestamp_table_core_tb.sv
// ----------------------------------------------------------------------------
// earliest_timestamp_table_core_tb
// Drives request words into the timestamp table and compares every response
// word with an in-bench table model: directed extremes, date edge cases,
// fill-to-full, long output hold-off, then random operation mixes.
// ----------------------------------------------------------------------------
module earliest_timestamp_table_core_tb;

    localparam int DEPTH     = ett_pkg::TABLE_DEPTH_DEF;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 4 * DEPTH + 20;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    ett_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_stall;
    ett_pkg::out_word_t out_data;

    // table model
    ett_pkg::entry_t    model_tab [DEPTH];
    int                 model_cnt;
    ett_pkg::out_word_t resp_q [$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  quiet;        // no random idling in the last part of the run
    bit  hold_long;    // request a long receiver hold-off
    int  hold_len;

    earliest_timestamp_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    function automatic bit is_leap(int y);
        return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    endfunction

    function automatic bit date_valid(int d, int m, int y);
        int lim;
        int days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (y < 1 || m < 1 || m > 12 || d < 1)
            return 0;
        lim = days[m - 1];
        if (m == 2 && is_leap(y))
            lim++;
        return d <= lim;
    endfunction

    function automatic logic [33:0] order_key(ett_pkg::entry_t e);
        return {e.year, e.month, e.day, e.hour, e.minute};
    endfunction

    function automatic int earliest_pos();
        int best;
        best = 0;
        for (int i = 1; i < model_cnt; i++)
            if (order_key(model_tab[i]) < order_key(model_tab[best]))
                best = i;
        return best;
    endfunction

    // Apply one request to the model and return the response it should give
    function automatic ett_pkg::out_word_t table_response(ett_pkg::in_word_t w);
        ett_pkg::out_word_t r;
        ett_pkg::entry_t    e;
        int                 i;
        r = '0;
        case (w.opcode) inside
            ett_pkg::OP_INSERT:
            begin
                if (!date_valid(w.day_in, w.month_in, w.year_in)
                    || w.hour_in > ett_pkg::HOUR_MAX || w.minute_in > ett_pkg::MINUTE_MAX)
                    r.status = ett_pkg::ST_BAD;
                else if (model_cnt >= DEPTH)
                    r.status = ett_pkg::ST_FULL;
                else
                begin
                    e.owner  = w.owner_id;
                    e.year   = w.year_in;
                    e.month  = w.month_in;
                    e.day    = w.day_in;
                    e.hour   = w.hour_in;
                    e.minute = w.minute_in;
                    model_tab[model_cnt] = e;
                    model_cnt++;
                end
                r.tally = 7'(model_cnt);
            end
            ett_pkg::OP_COUNT:
            begin
                if (!date_valid(w.day_in, w.month_in, w.year_in))
                    r.status = ett_pkg::ST_BAD;
                else
                    for (i = 0; i < model_cnt; i++)
                        if (model_tab[i].day == w.day_in && model_tab[i].month == w.month_in
                            && model_tab[i].year == w.year_in)
                            r.tally = r.tally + 7'd1;
            end
            ett_pkg::OP_READ_MIN, ett_pkg::OP_DEL_MIN:
            begin
                if (model_cnt == 0)
                    r.status = ett_pkg::ST_EMPTY;
                else
                begin
                    i              = earliest_pos();
                    e              = model_tab[i];
                    r.first_owner  = e.owner;
                    r.first_day    = e.day;
                    r.first_month  = e.month;
                    r.first_year   = e.year;
                    r.first_hour   = e.hour;
                    r.first_minute = e.minute;
                    if (w.opcode == ett_pkg::OP_DEL_MIN)
                    begin
                        model_cnt--;
                        model_tab[i] = model_tab[model_cnt];
                        r.tally      = 7'd1;
                    end
                    else
                        r.tally = 7'(model_cnt);
                end
            end
            ett_pkg::OP_DEL_OWNER:
            begin
                i = 0;
                while (i < model_cnt)
                    if (model_tab[i].owner == w.owner_id)
                    begin
                        model_cnt--;
                        model_tab[i] = model_tab[model_cnt];
                        r.tally = r.tally + 7'd1;
                    end
                    else
                        i++;
            end
            default:
                r.tally = 7'(model_cnt);
        endcase
        return r;
    endfunction

    // Send one word, record its expected response on acceptance, then drop
    // valid while the block is busy
    task automatic send_word(ett_pkg::in_word_t w, bit may_idle);
        int gap;
        if (may_idle && !quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        resp_q = {resp_q, table_response(w)};
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic ett_pkg::in_word_t make_word(int op, int id, int d, int m, int y,
                                                    int h, int mi);
        ett_pkg::in_word_t w;
        w.opcode    = 3'(op);
        w.owner_id  = 16'(id);
        w.day_in    = 5'(d);
        w.month_in  = 4'(m);
        w.year_in   = 14'(y);
        w.hour_in   = 5'(h);
        w.minute_in = 6'(mi);
        return w;
    endfunction

    // Random well-formed entry, usually from a narrow date set so that
    // counts and ties occur
    function automatic ett_pkg::in_word_t random_insert(int ids);
        int m;
        int y;
        m = $urandom_range(1, 12);
        y = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16383) : $urandom_range(1999, 2001);
        return make_word(ett_pkg::OP_INSERT, $urandom_range(0, ids), $urandom_range(1, 28), m,
                         y, $urandom_range(0, 23), $urandom_range(0, 59));
    endfunction

    task automatic wait_empty();
        while (resp_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stall: long hold-off on request, otherwise random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_len  <= 0;
        end
        else if (hold_long)
        begin
            out_stall <= 1'b1;
            hold_len  <= 400;
        end
        else if (hold_len > 0)
        begin
            hold_len <= hold_len - 1;
            if (hold_len == 1)
                out_stall <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            hold_len  <= $urandom_range(1, 18);
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each response word with the oldest expectation
    always @(posedge clk)
    begin
        ett_pkg::out_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (resp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response %h", out_data);
            end
            else
            begin
                exp_w = resp_q.pop_front();
                if (out_data !== exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: response mismatch exp st=%0d t=%0d o=%h %0d/%0d/%0d %0d:%0d",
                                 exp_w.status, exp_w.tally, exp_w.first_owner, exp_w.first_day,
                                 exp_w.first_month, exp_w.first_year, exp_w.first_hour,
                                 exp_w.first_minute);
                        $display("       got st=%0d t=%0d o=%h %0d/%0d/%0d %0d:%0d",
                                 out_data.status, out_data.tally, out_data.first_owner,
                                 out_data.first_day, out_data.first_month,
                                 out_data.first_year, out_data.first_hour,
                                 out_data.first_minute);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_empty_and_unused();
        send_word(make_word(ett_pkg::OP_READ_MIN, 0, 0, 0, 0, 0, 0), 1);
        send_word(make_word(ett_pkg::OP_DEL_MIN, 16'hffff, 31, 15, 16383, 31, 63), 1);
        send_word(make_word(ett_pkg::OP_DEL_OWNER, 5, 1, 1, 1, 0, 0), 1);
        for (int op = 5; op < 8; op++)
            send_word(make_word(op, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom), 1);
    endtask

    task automatic test_date_checks();
        send_word(make_word(ett_pkg::OP_INSERT, 1, 29, 2, 2000, 0, 0), 1);    // leap by 400
        send_word(make_word(ett_pkg::OP_INSERT, 2, 29, 2, 1900, 0, 0), 1);    // not leap, by 100
        send_word(make_word(ett_pkg::OP_INSERT, 3, 29, 2, 2004, 23, 59), 1);  // leap by 4
        send_word(make_word(ett_pkg::OP_INSERT, 4, 29, 2, 2003, 12, 0), 1);
        send_word(make_word(ett_pkg::OP_INSERT, 5, 31, 4, 2010, 1, 1), 1);
        send_word(make_word(ett_pkg::OP_INSERT, 6, 1, 1, 0, 1, 1), 1);
        send_word(make_word(ett_pkg::OP_INSERT, 7, 0, 1, 5, 1, 1), 1);
        send_word(make_word(ett_pkg::OP_INSERT, 8, 1, 13, 5, 1, 1), 1);
        send_word(make_word(ett_pkg::OP_INSERT, 9, 1, 0, 5, 1, 1), 1);
        send_word(make_word(ett_pkg::OP_INSERT, 10, 1, 1, 5, 24, 1), 1);
        send_word(make_word(ett_pkg::OP_INSERT, 11, 1, 1, 5, 1, 60), 1);
        send_word(make_word(ett_pkg::OP_INSERT, 16'hffff, 31, 12, 16383, 23, 59), 1);
        send_word(make_word(ett_pkg::OP_INSERT, 0, 1, 1, 1, 0, 0), 1);
        send_word(make_word(ett_pkg::OP_INSERT, 12, 1, 1, 1, 0, 0), 1);     // tie, first wins
        send_word(make_word(ett_pkg::OP_COUNT, 0, 1, 1, 1, 31, 63), 1);
        send_word(make_word(ett_pkg::OP_COUNT, 0, 29, 2, 1900, 0, 0), 1);
        send_word(make_word(ett_pkg::OP_READ_MIN, 0, 0, 0, 0, 0, 0), 1);
        send_word(make_word(ett_pkg::OP_DEL_MIN, 0, 0, 0, 0, 0, 0), 1);
        send_word(make_word(ett_pkg::OP_DEL_MIN, 0, 0, 0, 0, 0, 0), 1);
        send_word(make_word(ett_pkg::OP_DEL_OWNER, 16'hffff, 0, 0, 0, 0, 0), 1);
    endtask

    // Fill to full under a long receiver hold-off, then clear by owner
    task automatic test_full_and_backpressure();
        wait_empty();
        hold_long <= 1'b1;
        @(posedge clk);
        hold_long <= 1'b0;
        for (int i = 0; i < DEPTH + 3; i++)
            send_word(make_word(ett_pkg::OP_INSERT, i % 3, 1 + i % 28, 1 + i % 12, 2000,
                                i % 24, i % 60), 0);
        send_word(make_word(ett_pkg::OP_DEL_OWNER, 1, 0, 0, 0, 0, 0), 1);
        send_word(make_word(ett_pkg::OP_DEL_OWNER, 0, 0, 0, 0, 0, 0), 1);
        send_word(make_word(ett_pkg::OP_DEL_OWNER, 2, 0, 0, 0, 0, 0), 1);
        wait_empty();
    endtask

    task automatic test_random_mix(int n);
        ett_pkg::in_word_t w;
        int                pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 19);
            if (k == n / 2)
                quiet = 1'b1;
            if (pick < 8)
                w = random_insert(($urandom_range(0, 3) == 0) ? 65535 : 7);
            else if (pick < 10)
                w = make_word(ett_pkg::OP_COUNT, $urandom, $urandom_range(1, 28),
                              $urandom_range(1, 12), $urandom_range(1999, 2001), $urandom,
                              $urandom);
            else if (pick < 12)
                w = make_word(ett_pkg::OP_READ_MIN, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
            else if (pick < 15)
                w = make_word(ett_pkg::OP_DEL_MIN, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
            else if (pick < 16)
                w = make_word(ett_pkg::OP_DEL_OWNER, $urandom_range(0, 7), $urandom, $urandom,
                              $urandom, $urandom, $urandom);
            else
                // raw noise across every field bit
                w = make_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
            send_word(w, 1);
            if (k == n / 4)
                wait_empty();
        end
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        model_cnt  = 0;
        quiet      = 1'b0;
        hold_long  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_unused();
        test_date_checks();
        test_full_and_backpressure();
        test_random_mix(1000);

        wait_empty();
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0 && resp_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
